/* rtl/smsl_pkg.sv */
// Package for the stepped motor speed level block.
// Register indexes, command and mode codes, reset values and the table reset function.
// No dependencies.
package smsl_pkg;

    localparam int PULSE_W = 16;
    localparam int STEP_W  = 10;
    localparam int LVL_W   = 4;
    localparam int POS_W   = 12;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_PULSE   = 3'd0;
    localparam logic [2:0] REG_MAX_PULSE   = 3'd1;
    localparam logic [2:0] REG_COARSE_STEP = 3'd2;
    localparam logic [2:0] REG_FINE_STEP   = 3'd3;
    localparam logic [2:0] REG_SPIN_MODE   = 3'd4;

    // spin modes
    localparam logic [1:0] MODE_TOPSPIN  = 2'd0;
    localparam logic [1:0] MODE_BACKSPIN = 2'd1;
    localparam logic [1:0] MODE_NOSPIN   = 2'd2;
    localparam logic [1:0] MODE_SUPPORT  = 2'd3;

    // commands
    localparam logic [2:0] CMD_STEP_UP    = 3'd0;
    localparam logic [2:0] CMD_STEP_DOWN  = 3'd1;
    localparam logic [2:0] CMD_NUDGE_UP   = 3'd2;
    localparam logic [2:0] CMD_NUDGE_DOWN = 3'd3;
    localparam logic [2:0] CMD_SET_LEVEL  = 3'd4;
    localparam logic [2:0] CMD_STOP       = 3'd5;
    localparam logic [2:0] CMD_RAW_PULSE  = 3'd6;
    localparam logic [2:0] CMD_WRITE      = 3'd7;

    // register reset values
    localparam logic [15:0] MIN_PULSE_RST   = 16'd1000;
    localparam logic [15:0] MAX_PULSE_RST   = 16'd2000;
    localparam logic [9:0]  COARSE_STEP_RST = 10'd30;
    localparam logic [9:0]  FINE_STEP_RST   = 10'd4;
    localparam logic [1:0]  SPIN_MODE_RST   = MODE_TOPSPIN;
    localparam logic [15:0] SETPOINT_RST    = 16'd1000;

    // reset value of table entry idx (idx >= 1): 1240 + 60 * (idx - 1)
    function automatic logic [15:0] table_reset(input logic [3:0] idx);
        logic [31:0] v;
        v = 32'd1180 + 32'd60 * 32'(idx);
        return v[15:0];
    endfunction

endpackage

/* rtl/stepped_motor_speed_levels.sv */
// Stepped motor speed levels: setpoint and level control over a speed table.
// Depends on smsl_pkg and smsl_ram.
//
// Usage:
//   s_axis carries one command per beat; m_axis returns one result beat for each.
//   cfg writes the five registers (index 0..4); cfg_ready is always high. Write
//   configuration only while the block is idle.
//   Entries 1..NUM_LEVELS of the speed table live in a one-port-read RAM with
//   registered read data; each comparison against an entry needs a read.
//   The shortest commands (stop; raw pulse or write entry at level 0 or top) go
//   from start through the position step to publish; the longest is a nudge
//   from level 0: load entry 1, prepare, scan the whole table, read both bounds,
//   then a shift-subtract divide for the 8-bit position fraction.
//   One command is in flight at a time; s_axis_tready is high in the idle state,
//   so the next command is taken at the earliest in the cycle after its result
//   is loaded.
//   Results sit in an output register, so a new command is taken while the last
//   result waits; if the receiver stalls, the next result is held until the
//   register empties.
//   Reset: registers return to their defaults, setpoint 1000, level 0, and all
//   table entries read as 1240 + 60 per level through per-entry valid bits; no
//   clearing pass is needed.
module stepped_motor_speed_levels
    import smsl_pkg::*;
#(
    parameter int NUM_LEVELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // command beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] command, [6:3] level, [14:7] amount, [30:15] pulse_value, [31] zero
    input  logic [31:0] s_axis_tdata,
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] pulse_width, [16] running, [20:17] level_now, [32:21] position_q8,
    // [39:33] zero
    output logic [39:0] m_axis_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(NUM_LEVELS);
    localparam logic [LVL_W-1:0] TOP = LVL_W'(NUM_LEVELS);

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_START    = 16'h0002,
        ST_UP_LOAD  = 16'h0004,
        ST_UP_NEXT  = 16'h0008,
        ST_UP_TOP   = 16'h0010,
        ST_DN_ONE   = 16'h0020,
        ST_DN_CUR   = 16'h0040,
        ST_NU_LOAD  = 16'h0080,
        ST_NU_PREP  = 16'h0100,
        ST_SCAN     = 16'h0200,
        ST_SET_LOAD = 16'h0400,
        ST_POS_GO   = 16'h0800,
        ST_POS_LO   = 16'h1000,
        ST_POS_HI   = 16'h2000,
        ST_DIV      = 16'h4000,
        ST_PUB      = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] min_pulse_reg, max_pulse_reg;
    logic [9:0]  coarse_step_reg, fine_step_reg;
    logic [1:0]  spin_mode_reg;

    // block state
    logic [15:0]         sp_reg, sp_next;
    logic [LVL_W-1:0]    cur_reg, cur_next;
    logic [NUM_LEVELS-1:0] valid_reg;

    // command in flight
    logic [2:0]       cmd_reg;
    logic [LVL_W-1:0] lvl_in_reg;
    logic [7:0]       amt_reg;
    logic [15:0]      pv_reg;
    logic [9:0]       ms_reg;

    // working registers
    logic [16:0]      s_reg, s_next;
    logic [LVL_W-1:0] idx_reg, idx_next;
    logic [LVL_W-1:0] rd_idx_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic [15:0]      lo_reg, lo_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      den_reg, den_next;
    logic [7:0]       q_reg, q_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      out_pw_reg;
    logic             out_on_reg;
    logic [LVL_W-1:0] out_lvl_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic             out_load;

    // table access
    logic [LVL_W-1:0] fetch_idx;
    logic [AW-1:0]    fetch_addr;
    logic [15:0]      ram_q;
    logic [15:0]      ent;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;

    logic             in_fire;
    logic [9:0]       ms_cfg;
    logic [16:0]      sum_amt;
    logic [16:0]      rem2;
    logic             qbit;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        unique case (spin_mode_reg)
            MODE_SUPPORT: ms_cfg = fine_step_reg;
            MODE_NOSPIN:  ms_cfg = coarse_step_reg >> 1;
            default:      ms_cfg = coarse_step_reg;
        endcase
    end

    // entry value of the index read last cycle; entry 0 is min_pulse
    always_comb
    begin
        if (rd_idx_reg == '0)
        begin
            ent = min_pulse_reg;
        end
        else if (rd_idx_reg > TOP)
        begin
            ent = '0;
        end
        else if (valid_reg[rd_addr_reg])
        begin
            ent = ram_q;
        end
        else
        begin
            ent = table_reset(rd_idx_reg);
        end
    end

    assign fetch_addr = (fetch_idx == '0) ? '0 : AW'(fetch_idx - LVL_W'(1));

    assign ram_we    = (state_reg == ST_START) && (cmd_reg == CMD_WRITE)
                       && (lvl_in_reg != '0) && (lvl_in_reg <= TOP);
    assign ram_waddr = AW'(lvl_in_reg - LVL_W'(1));

    smsl_ram #(
        .WIDTH (PULSE_W),
        .DEPTH (NUM_LEVELS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pv_reg),
        .raddr (fetch_addr),
        .rdata (ram_q)
    );

    assign sum_amt = {1'b0, sp_reg} + 17'(amt_reg);
    assign rem2    = {rem_reg, 1'b0};
    assign qbit    = (rem2 >= {1'b0, den_reg});

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        cur_next       = cur_reg;
        s_next         = s_reg;
        idx_next       = idx_reg;
        lo_next        = lo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        fetch_idx      = rd_idx_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg;

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_START;
                end
            end

            ST_START:
            begin
                state_next = ST_POS_GO;
                case (cmd_reg) inside
                    CMD_STEP_UP:
                    begin
                        s_next = {1'b0, sp_reg} + 17'(ms_reg);
                        if (cur_reg == '0)
                        begin
                            fetch_idx  = LVL_W'(1);
                            state_next = ST_UP_LOAD;
                        end
                        else if (cur_reg < TOP)
                        begin
                            fetch_idx  = cur_reg + LVL_W'(1);
                            state_next = ST_UP_NEXT;
                        end
                        else
                        begin
                            fetch_idx  = TOP;
                            state_next = ST_UP_TOP;
                        end
                    end
                    CMD_STEP_DOWN:
                    begin
                        s_next     = (sp_reg > 16'(ms_reg)) ? 17'(sp_reg - 16'(ms_reg)) : '0;
                        fetch_idx  = LVL_W'(1);
                        state_next = ST_DN_ONE;
                    end
                    CMD_NUDGE_UP, CMD_NUDGE_DOWN:
                    begin
                        if (cur_reg == '0)
                        begin
                            fetch_idx  = LVL_W'(1);
                            state_next = ST_NU_LOAD;
                        end
                        else
                        begin
                            state_next = ST_NU_PREP;
                        end
                    end
                    CMD_SET_LEVEL:
                    begin
                        fetch_idx  = (lvl_in_reg > TOP) ? TOP : lvl_in_reg;
                        state_next = ST_SET_LOAD;
                    end
                    CMD_STOP:
                    begin
                        cur_next = '0;
                        sp_next  = min_pulse_reg;
                    end
                    CMD_RAW_PULSE:
                    begin
                        sp_next = pv_reg;
                    end
                    default:
                    begin
                        // table write handled by ram_we
                    end
                endcase
            end

            ST_UP_LOAD:
            begin
                cur_next   = LVL_W'(1);
                sp_next    = ent;
                state_next = ST_POS_GO;
            end

            ST_UP_NEXT:
            begin
                if (s_reg >= {1'b0, ent})
                begin
                    cur_next = cur_reg + LVL_W'(1);
                end
                fetch_idx  = TOP;
                state_next = ST_UP_TOP;
            end

            ST_UP_TOP:
            begin
                if (s_reg > {1'b0, ent})
                begin
                    cur_next = TOP;
                    sp_next  = ent;
                end
                else
                begin
                    sp_next = s_reg[15:0];
                end
                state_next = ST_POS_GO;
            end

            ST_DN_ONE:
            begin
                if (s_reg < {1'b0, ent})
                begin
                    cur_next   = '0;
                    sp_next    = min_pulse_reg;
                    state_next = ST_POS_GO;
                end
                else
                begin
                    fetch_idx  = cur_reg;
                    state_next = ST_DN_CUR;
                end
            end

            ST_DN_CUR:
            begin
                if ((s_reg < {1'b0, ent}) && (cur_reg != '0))
                begin
                    cur_next = cur_reg - LVL_W'(1);
                end
                sp_next    = s_reg[15:0];
                state_next = ST_POS_GO;
            end

            ST_NU_LOAD:
            begin
                cur_next   = LVL_W'(1);
                sp_next    = ent;
                state_next = ST_NU_PREP;
            end

            ST_NU_PREP:
            begin
                if (cmd_reg == CMD_NUDGE_UP)
                begin
                    s_next    = (sum_amt > {1'b0, max_pulse_reg}) ? {1'b0, max_pulse_reg}
                                                                  : sum_amt;
                    idx_next  = LVL_W'(1);
                    fetch_idx = LVL_W'(1);
                end
                else
                begin
                    s_next    = (sp_reg > 16'(amt_reg)) ? 17'(sp_reg - 16'(amt_reg)) : '0;
                    if (s_next < {1'b0, min_pulse_reg})
                    begin
                        s_next = {1'b0, min_pulse_reg};
                    end
                    idx_next  = TOP;
                    fetch_idx = TOP;
                end
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                if (cmd_reg == CMD_NUDGE_UP)
                begin
                    if ((s_reg >= {1'b0, ent}) && (idx_reg != TOP))
                    begin
                        cur_next  = idx_reg;
                        idx_next  = idx_reg + LVL_W'(1);
                        fetch_idx = idx_reg + LVL_W'(1);
                    end
                    else
                    begin
                        if (s_reg >= {1'b0, ent})
                        begin
                            cur_next = idx_reg;
                        end
                        sp_next    = s_reg[15:0];
                        state_next = ST_POS_GO;
                    end
                end
                else
                begin
                    if ((s_reg <= {1'b0, ent}) && (idx_reg != LVL_W'(1)))
                    begin
                        cur_next  = idx_reg;
                        idx_next  = idx_reg - LVL_W'(1);
                        fetch_idx = idx_reg - LVL_W'(1);
                    end
                    else
                    begin
                        if (s_reg <= {1'b0, ent})
                        begin
                            cur_next = idx_reg;
                        end
                        sp_next    = s_reg[15:0];
                        state_next = ST_POS_GO;
                    end
                end
            end

            ST_SET_LOAD:
            begin
                cur_next   = rd_idx_reg;
                sp_next    = ent;
                state_next = ST_POS_GO;
            end

            ST_POS_GO:
            begin
                if (cur_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = ST_PUB;
                end
                else if (cur_reg >= TOP)
                begin
                    pos_next   = {TOP, 8'd0};
                    state_next = ST_PUB;
                end
                else
                begin
                    fetch_idx  = cur_reg;
                    state_next = ST_POS_LO;
                end
            end

            ST_POS_LO:
            begin
                lo_next    = ent;
                fetch_idx  = cur_reg + LVL_W'(1);
                state_next = ST_POS_HI;
            end

            ST_POS_HI:
            begin
                if (sp_reg <= lo_reg)
                begin
                    pos_next   = {cur_reg, 8'd0};
                    state_next = ST_PUB;
                end
                else if (sp_reg >= ent)
                begin
                    pos_next   = {cur_reg + LVL_W'(1), 8'd0};
                    state_next = ST_PUB;
                end
                else
                begin
                    // lo < setpoint < hi, so the quotient fits in 8 bits
                    rem_next   = sp_reg - lo_reg;
                    den_next   = ent - lo_reg;
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next = qbit ? 16'(rem2 - {1'b0, den_reg}) : rem2[15:0];
                q_next   = {q_reg[6:0], qbit};
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    pos_next   = {cur_reg, q_reg[6:0], qbit};
                    state_next = ST_PUB;
                end
            end

            ST_PUB:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            min_pulse_reg   <= MIN_PULSE_RST;
            max_pulse_reg   <= MAX_PULSE_RST;
            coarse_step_reg <= COARSE_STEP_RST;
            fine_step_reg   <= FINE_STEP_RST;
            spin_mode_reg   <= SPIN_MODE_RST;
            sp_reg          <= SETPOINT_RST;
            cur_reg         <= '0;
            valid_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_MIN_PULSE:   min_pulse_reg   <= cfg_data;
                    REG_MAX_PULSE:   max_pulse_reg   <= cfg_data;
                    REG_COARSE_STEP: coarse_step_reg <= cfg_data[9:0];
                    REG_FINE_STEP:   fine_step_reg   <= cfg_data[9:0];
                    REG_SPIN_MODE:   spin_mode_reg   <= cfg_data[1:0];
                    default:         ;
                endcase
            end
        end
    end

    // payload, working and output data registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg    <= s_axis_tdata[2:0];
            lvl_in_reg <= s_axis_tdata[6:3];
            amt_reg    <= s_axis_tdata[14:7];
            pv_reg     <= s_axis_tdata[30:15];
            ms_reg     <= ms_cfg;
        end
        s_reg       <= s_next;
        idx_reg     <= idx_next;
        rd_idx_reg  <= fetch_idx;
        rd_addr_reg <= fetch_addr;
        lo_reg      <= lo_next;
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        q_reg       <= q_next;
        cnt_reg     <= cnt_next;
        pos_reg     <= pos_next;
        if (out_load)
        begin
            out_pw_reg  <= (sp_reg > min_pulse_reg) ? sp_reg : min_pulse_reg;
            out_on_reg  <= (sp_reg > min_pulse_reg);
            out_lvl_reg <= cur_reg;
            out_pos_reg <= pos_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_pos_reg, out_lvl_reg, out_on_reg, out_pw_reg};

endmodule

/* rtl/smsl_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module smsl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* tb/tb_stepped_motor_speed_levels.sv */
// Testbench for stepped_motor_speed_levels: directed command edges, spin modes, random phases.
// Keeps its own model of setpoint, level and speed table and checks every result beat.
// Depends on smsl_pkg and the RTL of stepped_motor_speed_levels.
`timescale 1ns / 1ps

module tb_stepped_motor_speed_levels;
    import smsl_pkg::*;

    localparam int TOP_LEVEL = 8;

    typedef struct {
        logic [15:0] pulse;
        logic        on;
        logic [3:0]  level;
        logic [11:0] pos;
    } motor_status_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    // model state
    logic [15:0] mdl_min;
    logic [15:0] mdl_max;
    logic [9:0]  mdl_coarse;
    logic [9:0]  mdl_fine;
    logic [1:0]  mdl_mode;
    logic [15:0] mdl_setpoint;
    logic [3:0]  mdl_level;
    logic [15:0] mdl_table [1:TOP_LEVEL];

    motor_status_t status_q[$];
    int            n_errors;
    int            n_beats;
    bit            steady;

    stepped_motor_speed_levels #(
        .NUM_LEVELS(TOP_LEVEL)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------- model

    function automatic int unsigned table_entry(input int unsigned idx);
        if (idx == 0)
            return mdl_min;
        if (idx <= TOP_LEVEL)
            return mdl_table[idx];
        return 0;
    endfunction

    function automatic int unsigned microstep_size();
        if (mdl_mode == MODE_SUPPORT)
            return mdl_fine;
        if (mdl_mode == MODE_NOSPIN)
            return mdl_coarse >> 1;
        return mdl_coarse;
    endfunction

    function automatic void model_reset();
        mdl_min      = MIN_PULSE_RST;
        mdl_max      = MAX_PULSE_RST;
        mdl_coarse   = COARSE_STEP_RST;
        mdl_fine     = FINE_STEP_RST;
        mdl_mode     = SPIN_MODE_RST;
        mdl_setpoint = SETPOINT_RST;
        mdl_level    = '0;
        for (int i = 1; i <= TOP_LEVEL; i++)
            mdl_table[i] = 16'(1240 + 60 * (i - 1));
    endfunction

    // applies one command and returns the status the block should report
    function automatic motor_status_t advance_motor(input logic [2:0] cmd,
                                                    input logic [3:0] lvl,
                                                    input logic [7:0] amt,
                                                    input logic [15:0] pv);
        motor_status_t st;
        int unsigned   s;
        int unsigned   lv;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   pos;
        int            i;
        lv = mdl_level;
        s  = mdl_setpoint;
        case (cmd)
            CMD_STEP_UP:
            begin
                s = s + microstep_size();
                if (lv == 0)
                begin
                    lv = 1;
                    s  = table_entry(1);
                end
                else
                begin
                    if (lv < TOP_LEVEL && s >= table_entry(lv + 1))
                        lv++;
                    if (s > table_entry(TOP_LEVEL))
                    begin
                        lv = TOP_LEVEL;
                        s  = table_entry(TOP_LEVEL);
                    end
                end
            end
            CMD_STEP_DOWN:
            begin
                s = (s > microstep_size()) ? s - microstep_size() : 0;
                if (s < table_entry(1))
                begin
                    lv = 0;
                    s  = table_entry(0);
                end
                else if (s < table_entry(lv) && lv > 0)
                    lv--;
            end
            CMD_NUDGE_UP:
            begin
                if (lv == 0)
                begin
                    lv = 1;
                    s  = table_entry(1);
                end
                s = s + amt;
                if (s > mdl_max)
                    s = mdl_max;
                for (i = 1; i <= TOP_LEVEL; i++)
                begin
                    if (s >= table_entry(i))
                        lv = i;
                    else
                        break;
                end
            end
            CMD_NUDGE_DOWN:
            begin
                if (lv == 0)
                begin
                    lv = 1;
                    s  = table_entry(1);
                end
                s = (s > amt) ? s - amt : 0;
                if (s < mdl_min)
                    s = mdl_min;
                for (i = TOP_LEVEL; i >= 1; i--)
                begin
                    if (s <= table_entry(i))
                        lv = i;
                    else
                        break;
                end
            end
            CMD_SET_LEVEL:
            begin
                lv = (lvl > TOP_LEVEL) ? TOP_LEVEL : lvl;
                s  = table_entry(lv);
            end
            CMD_STOP:
            begin
                lv = 0;
                s  = table_entry(0);
            end
            CMD_RAW_PULSE:
                s = pv;
            default:
            begin
                if (lvl >= 1 && lvl <= TOP_LEVEL)
                    mdl_table[lvl] = pv;
            end
        endcase
        mdl_level    = 4'(lv);
        mdl_setpoint = 16'(s);
        s = mdl_setpoint;

        if (lv == 0)
            pos = 0;
        else if (lv >= TOP_LEVEL)
            pos = TOP_LEVEL << 8;
        else
        begin
            lo = table_entry(lv);
            hi = table_entry(lv + 1);
            if (s <= lo)
                pos = lv << 8;
            else if (s >= hi)
                pos = (lv + 1) << 8;
            else
                pos = (lv << 8) + (((s - lo) << 8) / (hi - lo));
        end

        st.on    = (s > mdl_min);
        st.pulse = st.on ? mdl_setpoint : mdl_min;
        st.level = mdl_level;
        st.pos   = 12'(pos);
        return st;
    endfunction

    // ---------------------------------------------------------------- helpers

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(10, 20);
        return $urandom_range(30, 60);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] result beat %0d: %s got %0d, expected %0d",
                 $realtime, n_beats, what, got, want);
        n_errors++;
    endtask

    task automatic send_cmd(input logic [2:0] cmd, input logic [3:0] lvl,
                            input logic [7:0] amt, input logic [15:0] pv);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, pv, amt, lvl, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        status_q.push_back(advance_motor(cmd, lvl, amt, pv));
    endtask

    // sender stops and waits for every outstanding result
    task automatic wait_results_done();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MIN_PULSE:   mdl_min    = val;
            REG_MAX_PULSE:   mdl_max    = val;
            REG_COARSE_STEP: mdl_coarse = val[9:0];
            REG_FINE_STEP:   mdl_fine   = val[9:0];
            REG_SPIN_MODE:   mdl_mode   = val[1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] min_p, input logic [15:0] max_p,
                             input logic [9:0] coarse, input logic [9:0] fine,
                             input logic [1:0] mode);
        wait_results_done();
        write_reg(REG_MIN_PULSE, min_p);
        write_reg(REG_MAX_PULSE, max_p);
        write_reg(REG_COARSE_STEP, 16'(coarse));
        write_reg(REG_FINE_STEP, 16'(fine));
        write_reg(REG_SPIN_MODE, 16'(mode));
    endtask

    // pulse near the live table span most of the time, anything otherwise
    function automatic logic [15:0] near_pulse();
        int lo;
        int hi;
        int v;
        lo = table_entry(1);
        hi = table_entry(TOP_LEVEL);
        if (hi < lo)
        begin
            v  = lo;
            lo = hi;
            hi = v;
        end
        if ($urandom_range(0, 99) >= 80)
            return 16'($urandom_range(0, 65535));
        v = lo - 100 + $urandom_range(0, hi - lo + 200);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    // rising table above min_pulse, random spacing
    task automatic program_table();
        int base;
        int spread;
        int v;
        base   = mdl_min + $urandom_range(20, 300);
        spread = $urandom_range(5, 150);
        for (int i = 1; i <= TOP_LEVEL; i++)
        begin
            v = base + spread * (i - 1) + $urandom_range(0, spread / 2);
            if (v > 65535)
                v = 65535;
            send_cmd(CMD_WRITE, 4'(i), 8'($urandom_range(0, 255)), 16'(v));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_command_edges();
        send_cmd(CMD_STEP_UP, 4'd0, 8'd0, 16'd0);       // level 0 jumps to entry 1
        send_cmd(CMD_STEP_UP, 4'd0, 8'd0, 16'd0);
        send_cmd(CMD_STEP_UP, 4'd0, 8'd0, 16'd0);       // reaches entry 2
        send_cmd(CMD_STEP_DOWN, 4'd0, 8'd0, 16'd0);     // drops back a level
        send_cmd(CMD_NUDGE_UP, 4'd0, 8'd255, 16'd0);
        send_cmd(CMD_NUDGE_DOWN, 4'd0, 8'd255, 16'd0);
        send_cmd(CMD_NUDGE_DOWN, 4'd0, 8'd0, 16'd0);
        send_cmd(CMD_NUDGE_UP, 4'd0, 8'd0, 16'd0);
        send_cmd(CMD_SET_LEVEL, 4'd15, 8'd0, 16'd0);    // clamps to top
        send_cmd(CMD_STEP_UP, 4'd0, 8'd0, 16'd0);       // clamps at top entry
        send_cmd(CMD_SET_LEVEL, 4'd0, 8'd0, 16'd0);
        send_cmd(CMD_NUDGE_DOWN, 4'd0, 8'd255, 16'd0);  // loads level 1 first, raises to min
        send_cmd(CMD_WRITE, 4'd0, 8'd0, 16'hFFFF);      // out of range entries: ignored
        send_cmd(CMD_WRITE, 4'd9, 8'd0, 16'hFFFF);
        send_cmd(CMD_WRITE, 4'd15, 8'd0, 16'hFFFF);
        send_cmd(CMD_WRITE, 4'd3, 8'd0, 16'hFFFF);      // table no longer monotonic
        send_cmd(CMD_SET_LEVEL, 4'd2, 8'd0, 16'd0);
        send_cmd(CMD_NUDGE_UP, 4'd0, 8'd255, 16'd0);    // scan stops at the high entry
        send_cmd(CMD_RAW_PULSE, 4'd0, 8'd0, 16'd0);     // motor off, min pulse driven
        send_cmd(CMD_STEP_DOWN, 4'd0, 8'd0, 16'd0);     // saturates at zero
        send_cmd(CMD_RAW_PULSE, 4'd0, 8'd0, 16'hFFFF);
        send_cmd(CMD_STOP, 4'd0, 8'd0, 16'd0);
        send_cmd(CMD_WRITE, 4'd8, 8'd0, 16'd0);
    endtask

    task automatic test_spin_modes();
        logic [1:0] modes [4];
        modes = '{MODE_TOPSPIN, MODE_BACKSPIN, MODE_NOSPIN, MODE_SUPPORT};
        foreach (modes[m])
        begin
            // odd coarse step so the nospin halving truncates
            configure(16'd1000, 16'd2000, 10'd7, 10'd3, modes[m]);
            send_cmd(CMD_RAW_PULSE, 4'd0, 8'd0, 16'd1290);
            send_cmd(CMD_STEP_UP, 4'd0, 8'd0, 16'd0);
            send_cmd(CMD_STEP_DOWN, 4'd0, 8'd0, 16'd0);
        end
    endtask

    task automatic test_random_levels(input int n_phases, input int per_phase);
        int          r;
        logic [2:0]  cmd;
        logic [3:0]  lvl;
        logic [7:0]  amt;
        logic [15:0] pv;
        logic [15:0] min_p;
        for (int ph = 0; ph < n_phases; ph++)
        begin
            steady = (ph == 3);
            case (ph)
                0: configure(MIN_PULSE_RST, MAX_PULSE_RST, COARSE_STEP_RST,
                             FINE_STEP_RST, MODE_TOPSPIN);
                1: configure(16'd0, 16'hFFFF, 10'd1023, 10'd1023, MODE_BACKSPIN);
                2: configure(16'hFFFF, 16'd0, 10'd0, 10'd0, MODE_SUPPORT);
                3: configure(16'd500, 16'd3000, 10'd1, 10'd1, MODE_NOSPIN);
                default:
                begin
                    min_p = 16'($urandom_range(500, 1500));
                    configure(min_p, 16'(min_p + $urandom_range(300, 3000)),
                              10'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                            : $urandom_range(1, 80)),
                              10'($urandom_range(0, 20)), 2'($urandom_range(0, 3)));
                end
            endcase
            if (ph != 2)
                program_table();
            for (int k = 0; k < per_phase; k++)
            begin
                if ((ph == 1 && k == 50) || $urandom_range(0, 199) == 0)
                    wait_results_done();
                r   = $urandom_range(0, 99);
                lvl = 4'($urandom_range(0, 15));
                amt = 8'($urandom_range(0, 255));
                pv  = near_pulse();
                if (r < 28)
                    cmd = CMD_STEP_UP;
                else if (r < 48)
                    cmd = CMD_STEP_DOWN;
                else if (r < 60)
                    cmd = CMD_NUDGE_UP;
                else if (r < 72)
                    cmd = CMD_NUDGE_DOWN;
                else if (r < 78)
                    cmd = CMD_SET_LEVEL;
                else if (r < 81)
                    cmd = CMD_STOP;
                else if (r < 87)
                    cmd = CMD_RAW_PULSE;
                else if (r < 92)
                    cmd = CMD_WRITE;
                else
                begin
                    cmd = 3'($urandom_range(0, 7));
                    pv  = 16'($urandom_range(0, 65535));
                end
                send_cmd(cmd, lvl, amt, pv);
            end
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- result side

    initial
    begin
        int stall;
        stall         = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                m_axis_tready <= 1'b0;
            else if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    stall--;
                end
                else
                    m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        motor_status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (status_q.size() == 0)
                report_mismatch("unexpected beat, pulse_width", m_axis_tdata[15:0], 0);
            else
            begin
                want = status_q.pop_front();
                if (m_axis_tdata[15:0] !== want.pulse)
                    report_mismatch("pulse_width", m_axis_tdata[15:0], want.pulse);
                if (m_axis_tdata[16] !== want.on)
                    report_mismatch("running", m_axis_tdata[16], want.on);
                if (m_axis_tdata[20:17] !== want.level)
                    report_mismatch("level_now", m_axis_tdata[20:17], want.level);
                if (m_axis_tdata[32:21] !== want.pos)
                    report_mismatch("position_q8", m_axis_tdata[32:21], want.pos);
            end
            n_beats++;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        n_errors      = 0;
        n_beats       = 0;
        steady        = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        model_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_command_edges();
        test_spin_modes();
        test_random_levels(8, 90);

        wait_results_done();
        repeat (40) @(posedge clk);
        if (status_q.size() != 0)
            report_mismatch("results still outstanding", 0, status_q.size());
        if (n_errors == 0)
            $display("** stepped_motor_speed_levels: PASSED **");
        else
            $display("** stepped_motor_speed_levels: FAILED **");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("timeout with %0d results outstanding", status_q.size());
        $display("** stepped_motor_speed_levels: FAILED **");
        $finish;
    end

endmodule
